// ----- hw/rtl/evt_pkg.sv -----
// shared types, codes and microcode table of the moving-average tracker
`timescale 1ns / 1ps

package evt_pkg;

    // item command codes
    localparam logic [1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ALPHA     = 2'd0;
    localparam logic [1:0] CFG_INIT_VAL  = 2'd1;
    localparam logic [1:0] CFG_WD_LIMIT  = 2'd2;

    localparam int unsigned CFG_W     = 17;
    localparam int unsigned VAR_W     = 36;
    localparam logic [16:0] ALPHA_ONE = 17'h10000;
    localparam logic [16:0] ALPHA_RST = 17'd6554;

    localparam int unsigned STEP_W = 4;

    localparam logic [STEP_W-1:0] STEP_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DISPATCH = 4'd1;
    localparam logic [STEP_W-1:0] STEP_MUL      = 4'd2;
    localparam logic [STEP_W-1:0] STEP_UPDATE   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_TICK     = 4'd4;
    localparam logic [STEP_W-1:0] STEP_RESTART  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_VAR      = 4'd6;
    localparam logic [STEP_W-1:0] STEP_READ     = 4'd7;
    localparam logic [STEP_W-1:0] STEP_DRAIN0   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_DRAIN1   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_OUT      = 4'd10;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_MUL,
        OP_SAMPLE,
        OP_TICK,
        OP_RESTART,
        OP_VAR_CLR,
        OP_VAR_RD,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_WAIT_IN,
        J_DISPATCH,
        J_LOOP,
        J_WAIT_OUT
    } t_jmp;

    typedef struct packed {
        t_op               op;
        t_jmp              jmp;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic [16:0]        alpha;
        logic signed [15:0] init_val;
        logic [15:0]        wd_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0] cmd;
        logic       idx_last;
    } t_dp_stat;

    function automatic t_uword evt_ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            STEP_IDLE:     w = '{OP_NOP,     J_WAIT_IN,  STEP_DISPATCH};
            STEP_DISPATCH: w = '{OP_NOP,     J_DISPATCH, STEP_VAR};
            STEP_MUL:      w = '{OP_MUL,     J_NEXT,     STEP_UPDATE};
            STEP_UPDATE:   w = '{OP_SAMPLE,  J_GOTO,     STEP_VAR};
            STEP_TICK:     w = '{OP_TICK,    J_GOTO,     STEP_VAR};
            STEP_RESTART:  w = '{OP_RESTART, J_GOTO,     STEP_VAR};
            STEP_VAR:      w = '{OP_VAR_CLR, J_NEXT,     STEP_READ};
            STEP_READ:     w = '{OP_VAR_RD,  J_LOOP,     STEP_DRAIN0};
            STEP_DRAIN0:   w = '{OP_NOP,     J_NEXT,     STEP_DRAIN1};
            STEP_DRAIN1:   w = '{OP_NOP,     J_NEXT,     STEP_OUT};
            STEP_OUT:      w = '{OP_OUT,     J_WAIT_OUT, STEP_IDLE};
            default:       w = '{OP_NOP,     J_GOTO,     STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- hw/rtl/ema_variance_tracker.sv -----
// top level: config registers, stream ports, output register
// a sample steps through dispatch, multiply, update, ring walk, drain steps and output;
// a tick or restart takes its own step in place of multiply and update; the unused
// command goes straight to the ring walk, which reads the ram one entry a cycle;
// only idle takes an item; an untaken result in the output register holds the next one
// reset (i_rst_n low, synchronous): average, history, pointer, count cleared,
// alpha back to 6554, init_val and watchdog_limit to 0
`timescale 1ns / 1ps

module ema_variance_tracker #(
    parameter int unsigned HISTORY_DEPTH = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [15:0]               s_tdata,   // sample
    input  logic [1:0]                s_tuser,   // cmd
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [55:0]               m_tdata,   // average, variance_sum, zero pad
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_addr,
    input  logic [evt_pkg::CFG_W-1:0] i_cfg_data
);

    evt_pkg::t_cfg     r_cfg;
    evt_pkg::t_op      w_op;
    evt_pkg::t_dp_stat w_stat;
    logic              w_accept;
    logic              w_out_free;
    logic signed [15:0]        w_avg;
    logic [evt_pkg::VAR_W-1:0] w_var;
    logic                      r_out_valid;
    logic [15:0]               r_out_avg;
    logic [evt_pkg::VAR_W-1:0] r_out_var;

    assign w_accept   = s_tvalid && s_tready;
    assign w_out_free = !r_out_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha    <= evt_pkg::ALPHA_RST;
            r_cfg.init_val <= '0;
            r_cfg.wd_limit <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                evt_pkg::CFG_ALPHA:    r_cfg.alpha    <= i_cfg_data;
                evt_pkg::CFG_INIT_VAL: r_cfg.init_val <= signed'(i_cfg_data[15:0]);
                evt_pkg::CFG_WD_LIMIT: r_cfg.wd_limit <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    evt_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_in_ready (s_tready),
        .o_op       (w_op)
    );

    evt_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_accept  (w_accept),
        .i_cmd     (s_tuser),
        .i_sample  (signed'(s_tdata)),
        .i_op      (w_op),
        .o_stat    (w_stat),
        .o_average (w_avg),
        .o_var_sum (w_var)
    );

    // result waits here while the next item is taken in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_op == evt_pkg::OP_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_op == evt_pkg::OP_OUT && w_out_free) begin
            r_out_avg <= w_avg;
            r_out_var <= w_var;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'b0, r_out_var, r_out_avg};

endmodule

// ----- hw/rtl/evt_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module evt_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/evt_datapath.sv -----
// average, watchdog, history ring and squared-deviation accumulator
`timescale 1ns / 1ps

module evt_datapath #(
    parameter int unsigned HISTORY_DEPTH = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  evt_pkg::t_cfg              i_cfg,
    input  logic                       i_accept,
    input  logic [1:0]                 i_cmd,
    input  logic signed [15:0]         i_sample,
    input  evt_pkg::t_op               i_op,
    output evt_pkg::t_dp_stat          o_stat,
    output logic signed [15:0]         o_average,
    output logic [evt_pkg::VAR_W-1:0]  o_var_sum
);

    localparam int unsigned IDX_W = $clog2(HISTORY_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_DEPTH - 1);

    logic [1:0]                r_cmd;
    logic signed [15:0]        r_sample;
    logic signed [15:0]        r_avg, n_avg;
    logic signed [15:0]        r_fill, n_fill;
    logic [15:0]               r_cnt, n_cnt;
    logic [IDX_W-1:0]          r_ptr, n_ptr;
    logic [HISTORY_DEPTH-1:0]  r_valid, n_valid;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic signed [34:0]        r_prod;
    logic                      r_v1, r_v2, r_hit;
    logic [31:0]               r_sq;
    logic [evt_pkg::VAR_W-1:0] r_acc, n_acc;

    logic [16:0]        w_alpha;
    logic signed [16:0] w_diff;
    logic signed [17:0] w_alpha_s;
    logic signed [34:0] w_prod;
    logic signed [18:0] w_step;
    logic signed [18:0] w_sum;
    logic [15:0]        w_inc;
    logic               w_we;
    logic [15:0]        w_rdata;
    logic signed [15:0] w_entry;
    logic signed [16:0] w_dev;
    logic signed [33:0] w_sq;

    // alpha above one acts as one
    assign w_alpha   = (i_cfg.alpha > evt_pkg::ALPHA_ONE) ? evt_pkg::ALPHA_ONE : i_cfg.alpha;
    assign w_alpha_s = signed'({1'b0, w_alpha});
    assign w_diff    = 17'(r_sample) - 17'(r_avg);
    assign w_prod    = 35'(w_diff) * 35'(w_alpha_s);
    // arithmetic shift gives the floor
    assign w_step    = 19'(r_prod >>> 16);
    assign w_sum     = 19'(r_avg) + w_step;
    assign w_inc     = (r_cnt < i_cfg.wd_limit) ? r_cnt + 16'd1 : r_cnt;
    assign w_we      = (i_op == evt_pkg::OP_SAMPLE);

    evt_ram #(
        .WIDTH (16),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_ptr),
        .i_wdata (r_sample),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // entries not written since restart hold the fill value
    assign w_entry = r_hit ? signed'(w_rdata) : r_fill;
    assign w_dev   = 17'(w_entry) - 17'(r_avg);
    assign w_sq    = 34'(w_dev) * 34'(w_dev);

    always_comb begin
        n_avg   = r_avg;
        n_fill  = r_fill;
        n_cnt   = r_cnt;
        n_ptr   = r_ptr;
        n_valid = r_valid;
        n_idx   = r_idx;
        n_acc   = r_v2 ? r_acc + evt_pkg::VAR_W'(r_sq) : r_acc;
        case (i_op)
            evt_pkg::OP_SAMPLE: begin
                n_avg          = w_sum[15:0];
                n_cnt          = '0;
                n_valid[r_ptr] = 1'b1;
                n_ptr          = (r_ptr == IDX_LAST) ? '0 : r_ptr + IDX_W'(1);
            end
            evt_pkg::OP_TICK: begin
                if (i_cfg.wd_limit != '0) begin
                    if (w_inc >= i_cfg.wd_limit) begin
                        n_cnt = i_cfg.wd_limit;
                        n_avg = i_cfg.init_val;
                    end else begin
                        n_cnt = w_inc;
                    end
                end
            end
            evt_pkg::OP_RESTART: begin
                n_avg   = i_cfg.init_val;
                n_fill  = i_cfg.init_val;
                n_cnt   = '0;
                n_ptr   = '0;
                n_valid = '0;
            end
            evt_pkg::OP_VAR_CLR: begin
                n_idx = '0;
                n_acc = '0;
            end
            evt_pkg::OP_VAR_RD: begin
                n_idx = (r_idx == IDX_LAST) ? r_idx : r_idx + IDX_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg   <= '0;
            r_fill  <= '0;
            r_cnt   <= '0;
            r_ptr   <= '0;
            r_valid <= '0;
            r_idx   <= '0;
            r_acc   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_avg   <= n_avg;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
            r_ptr   <= n_ptr;
            r_valid <= n_valid;
            r_idx   <= n_idx;
            r_acc   <= n_acc;
            r_v1    <= (i_op == evt_pkg::OP_VAR_RD);
            r_v2    <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cmd    <= i_cmd;
            r_sample <= i_sample;
        end
        if (i_op == evt_pkg::OP_MUL) begin
            r_prod <= w_prod;
        end
        r_hit <= r_valid[r_idx];
        r_sq  <= w_sq[31:0];
    end

    assign o_stat.cmd      = r_cmd;
    assign o_stat.idx_last = (r_idx == IDX_LAST);
    assign o_average       = r_avg;
    assign o_var_sum       = r_acc;

endmodule

// ----- hw/rtl/evt_sequencer.sv -----
// step counter and microcode table driving the datapath
`timescale 1ns / 1ps

module evt_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_free,
    input  evt_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output evt_pkg::t_op      o_op
);

    logic [evt_pkg::STEP_W-1:0] r_step, n_step;
    evt_pkg::t_uword            w_uw;

    assign w_uw       = evt_pkg::evt_ucode(r_step);
    assign o_op       = w_uw.op;
    assign o_in_ready = (w_uw.jmp == evt_pkg::J_WAIT_IN);

    always_comb begin
        n_step = r_step + evt_pkg::STEP_W'(1);
        case (w_uw.jmp)
            evt_pkg::J_NEXT: begin
                n_step = w_uw.target;
            end
            evt_pkg::J_GOTO: begin
                n_step = w_uw.target;
            end
            evt_pkg::J_WAIT_IN: begin
                n_step = i_in_valid ? w_uw.target : r_step;
            end
            evt_pkg::J_DISPATCH: begin
                case (i_stat.cmd)
                    evt_pkg::CMD_SAMPLE:  n_step = evt_pkg::STEP_MUL;
                    evt_pkg::CMD_TICK:    n_step = evt_pkg::STEP_TICK;
                    evt_pkg::CMD_RESTART: n_step = evt_pkg::STEP_RESTART;
                    // unused command only reports
                    default:              n_step = w_uw.target;
                endcase
            end
            evt_pkg::J_LOOP: begin
                n_step = i_stat.idx_last ? w_uw.target : r_step;
            end
            evt_pkg::J_WAIT_OUT: begin
                n_step = i_out_free ? w_uw.target : r_step;
            end
            default: begin
                n_step = evt_pkg::STEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= evt_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ----- test/ema_variance_tracker_tb.sv -----
// testbench of the moving-average tracker: directed table, random phases, scoreboard on results
`timescale 1ns / 1ps

module ema_variance_tracker_tb;

    localparam int unsigned DEPTH         = 10;
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;
    localparam int unsigned NUM_PHASES    = 12;
    localparam int unsigned PHASE_ITEMS   = 105;
    localparam int unsigned SETTLE_CYCLES = DEPTH + 14;
    localparam int unsigned DRAIN_CYCLES  = 40;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned STALL_LIMIT   = 4000;

    typedef struct packed {
        logic [15:0] average;
        logic [35:0] var_sum;
    } t_ema_result;

    typedef struct packed {
        logic        cfg_we;
        logic [1:0]  cfg_addr;
        logic [16:0] cfg_data;
        logic [1:0]  cmd;
        logic [15:0] smp;
        logic        typed;
        logic [15:0] average;
        logic [35:0] var_sum;
    } t_row;

    localparam int unsigned NUM_ROWS = 24;

    // rows with typed results only where the answer is obvious
    localparam t_row DIRECTED [NUM_ROWS] = '{
        '{1'b0, evt_pkg::CFG_ALPHA, 17'd0,
          evt_pkg::CMD_TICK, 16'h0000, 1'b1, 16'h0000, 36'd0},
        '{1'b0, evt_pkg::CFG_ALPHA, 17'd0,
          CMD_UNUSED, 16'hFFFF, 1'b1, 16'h0000, 36'd0},
        '{1'b0, evt_pkg::CFG_ALPHA, 17'd0,
          evt_pkg::CMD_RESTART, 16'h0000, 1'b1, 16'h0000, 36'd0},
        '{1'b1, evt_pkg::CFG_ALPHA, evt_pkg::ALPHA_ONE,
          evt_pkg::CMD_SAMPLE, 16'h7FFF, 1'b0, 16'h0000, 36'd0},
        '{1'b0, evt_pkg::CFG_ALPHA, 17'd0,
          evt_pkg::CMD_SAMPLE, 16'h8000, 1'b0, 16'h0000, 36'd0},
        '{1'b1, evt_pkg::CFG_ALPHA, 17'h1FFFF,
          evt_pkg::CMD_SAMPLE, 16'h7FFF, 1'b0, 16'h0000, 36'd0},
        '{1'b1, evt_pkg::CFG_ALPHA, 17'd0,
          evt_pkg::CMD_SAMPLE, 16'h1234, 1'b0, 16'h0000, 36'd0},
        '{1'b1, evt_pkg::CFG_ALPHA, 17'd1,
          evt_pkg::CMD_SAMPLE, 16'h8000, 1'b0, 16'h0000, 36'd0},
        '{1'b1, evt_pkg::CFG_INIT_VAL, 17'h08000,
          evt_pkg::CMD_TICK, 16'h0000, 1'b0, 16'h0000, 36'd0},
        '{1'b1, evt_pkg::CFG_WD_LIMIT, 17'd3,
          evt_pkg::CMD_TICK, 16'h0000, 1'b0, 16'h0000, 36'd0},
        '{1'b0, evt_pkg::CFG_ALPHA, 17'd0,
          evt_pkg::CMD_TICK, 16'hFFFF, 1'b0, 16'h0000, 36'd0},
        '{1'b0, evt_pkg::CFG_ALPHA, 17'd0,
          evt_pkg::CMD_TICK, 16'h0000, 1'b0, 16'h0000, 36'd0},
        '{1'b0, evt_pkg::CFG_ALPHA, 17'd0,
          evt_pkg::CMD_TICK, 16'h0000, 1'b0, 16'h0000, 36'd0},
        '{1'b0, evt_pkg::CFG_ALPHA, 17'd0,
          evt_pkg::CMD_SAMPLE, 16'h0100, 1'b0, 16'h0000, 36'd0},
        '{1'b0, evt_pkg::CFG_ALPHA, 17'd0,
          evt_pkg::CMD_TICK, 16'h0000, 1'b0, 16'h0000, 36'd0},
        '{1'b0, evt_pkg::CFG_ALPHA, 17'd0,
          evt_pkg::CMD_TICK, 16'h0000, 1'b0, 16'h0000, 36'd0},
        '{1'b1, evt_pkg::CFG_WD_LIMIT, 17'd1,
          evt_pkg::CMD_TICK, 16'h0000, 1'b0, 16'h0000, 36'd0},
        '{1'b0, evt_pkg::CFG_ALPHA, 17'd0,
          evt_pkg::CMD_RESTART, 16'h0000, 1'b1, 16'h8000, 36'd0},
        '{1'b1, evt_pkg::CFG_INIT_VAL, 17'h07FFF,
          evt_pkg::CMD_RESTART, 16'h0000, 1'b1, 16'h7FFF, 36'd0},
        '{1'b1, evt_pkg::CFG_WD_LIMIT, 17'h0FFFF,
          evt_pkg::CMD_TICK, 16'h0000, 1'b1, 16'h7FFF, 36'd0},
        '{1'b1, evt_pkg::CFG_ALPHA, evt_pkg::ALPHA_RST,
          evt_pkg::CMD_SAMPLE, 16'h5555, 1'b0, 16'h0000, 36'd0},
        '{1'b0, evt_pkg::CFG_ALPHA, 17'd0,
          evt_pkg::CMD_SAMPLE, 16'hAAAA, 1'b0, 16'h0000, 36'd0},
        '{1'b0, evt_pkg::CFG_ALPHA, 17'd0,
          CMD_UNUSED, 16'h5555, 1'b0, 16'h0000, 36'd0},
        '{1'b1, evt_pkg::CFG_WD_LIMIT, 17'd0,
          evt_pkg::CMD_TICK, 16'h0000, 1'b0, 16'h0000, 36'd0}
    };

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              s_tvalid   = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata    = '0;   // sample
    logic [1:0]        s_tuser    = '0;   // cmd
    logic              m_tvalid;
    logic              m_tready   = 1'b0;
    logic [55:0]       m_tdata;           // average, variance_sum, zero pad
    logic              i_cfg_we   = 1'b0;
    logic [1:0]        i_cfg_addr = '0;
    logic [evt_pkg::CFG_W-1:0] i_cfg_data = '0;

    // model state and its copy of the registers
    logic [16:0]        model_alpha = evt_pkg::ALPHA_RST;
    logic signed [15:0] model_init  = '0;
    logic [15:0]        model_limit = '0;
    logic signed [15:0] model_avg   = '0;
    logic signed [15:0] model_ring [DEPTH];
    int unsigned        model_ptr   = 0;
    logic [15:0]        model_ticks = '0;

    t_ema_result pending_results [$];
    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;
    int unsigned hold_left   = 0;
    bit          hold_req    = 1'b0;
    bit          no_idle     = 1'b0;

    ema_variance_tracker #(
        .HISTORY_DEPTH(DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < DEPTH; i++) model_ring[i] = '0;
    end

    // advances the model by one item and returns the average and deviation sum
    function automatic t_ema_result ema_step(input logic [1:0] cmd, input logic signed [15:0] smp);
        t_ema_result res;
        logic [16:0] weight;
        longint      diff;
        longint      prod;
        longint      dev;
        logic [35:0] acc;
        case (cmd)
            evt_pkg::CMD_SAMPLE: begin
                weight = (model_alpha > evt_pkg::ALPHA_ONE) ? evt_pkg::ALPHA_ONE : model_alpha;
                diff = longint'(smp) - longint'(model_avg);
                prod = diff * longint'(weight);
                // arithmetic shift gives the floor for negative products
                model_avg = 16'(longint'(model_avg) + (prod >>> 16));
                model_ticks = '0;
                model_ring[model_ptr] = smp;
                model_ptr = (model_ptr == DEPTH - 1) ? 0 : model_ptr + 1;
            end
            evt_pkg::CMD_TICK: begin
                if (model_limit != 0) begin
                    if (model_ticks < model_limit) model_ticks = model_ticks + 1'b1;
                    // count may sit above a lowered limit
                    if (model_ticks >= model_limit) begin
                        model_ticks = model_limit;
                        model_avg = model_init;
                    end
                end
            end
            evt_pkg::CMD_RESTART: begin
                model_avg = model_init;
                for (int i = 0; i < DEPTH; i++) model_ring[i] = model_init;
                model_ptr = 0;
                model_ticks = '0;
            end
            default: begin
            end
        endcase
        acc = '0;
        for (int i = 0; i < DEPTH; i++) begin
            dev = longint'(model_ring[i]) - longint'(model_avg);
            acc = acc + 36'(dev * dev);
        end
        res.average = model_avg;
        res.var_sum = acc;
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        mismatches++;
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    task automatic send_item(input logic [1:0] cmd, input logic [15:0] smp,
                             input logic typed, input t_ema_result typed_res);
        t_ema_result res;
        while (!no_idle && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= smp;
        do @(posedge i_clk); while (s_tready !== 1'b1);
        res = ema_step(cmd, smp);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // lets every item drain so registers are written while the block is idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] addr, input logic [16:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            evt_pkg::CFG_ALPHA:    model_alpha = data;
            evt_pkg::CFG_INIT_VAL: model_init  = data[15:0];
            evt_pkg::CFG_WD_LIMIT: model_limit = data[15:0];
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    // receiver side: random stalls, a phase without stalls and one long hold-off
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 16);
        end
    end

    always @(posedge i_clk) begin
        t_ema_result want;
        if (i_rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result with nothing expected", m_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[15:0] !== want.average)
                    flag_mismatch("average", m_tdata[15:0], want.average);
                if (m_tdata[51:16] !== want.var_sum)
                    flag_mismatch("variance_sum", m_tdata[51:16], want.var_sum);
                if (m_tdata[55:52] !== 4'h0)
                    flag_mismatch("pad bits", m_tdata[55:52], 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_row        row;
        logic [16:0] alpha_pick;
        logic [15:0] init_pick;
        logic [15:0] limit_pick;
        logic [15:0] smp_pick;
        int unsigned sent;
        int unsigned burst;
        int unsigned roll;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < NUM_ROWS; k++) begin
            row = DIRECTED[k];
            if (row.cfg_we) begin
                settle();
                write_cfg(row.cfg_addr, row.cfg_data);
            end
            send_item(row.cmd, row.smp, row.typed, '{row.average, row.var_sum});
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            alpha_pick = (ph == 1) ? 17'd0 :
                         (ph == 2) ? evt_pkg::ALPHA_ONE :
                         (ph == 3) ? 17'h1FFFF :
                         (ph == 5) ? 17'd1 : 17'($urandom_range(1, 65536));
            init_pick  = (ph % 4 == 0) ? 16'h8000 :
                         (ph % 4 == 1) ? 16'h7FFF : 16'($urandom);
            limit_pick = (ph == 7) ? 16'hFFFF :
                         (ph == 9) ? 16'($urandom) :
                         (ph % 3 == 0) ? 16'd0 : 16'($urandom_range(1, 6));
            write_cfg(evt_pkg::CFG_ALPHA, alpha_pick);
            write_cfg(evt_pkg::CFG_INIT_VAL, {1'b0, init_pick});
            write_cfg(evt_pkg::CFG_WD_LIMIT, {1'b0, limit_pick});
            no_idle = (ph == 4);
            if (ph == 6) hold_req = 1'b1;

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                roll = $urandom_range(99);
                smp_pick = ($urandom_range(7) == 0) ?
                           ($urandom_range(1) ? 16'h7FFF : 16'h8000) : 16'($urandom);
                if (roll < 66) begin
                    send_item(evt_pkg::CMD_SAMPLE, smp_pick, 1'b0, '0);
                    sent++;
                end else if (roll < 84) begin
                    // runs of ticks so small limits get reached
                    burst = $urandom_range(1, 8);
                    repeat (burst) send_item(evt_pkg::CMD_TICK, smp_pick, 1'b0, '0);
                    sent += burst;
                end else if (roll < 92) begin
                    send_item(evt_pkg::CMD_RESTART, smp_pick, 1'b0, '0);
                    sent++;
                end else begin
                    send_item(CMD_UNUSED, smp_pick, 1'b0, '0);
                    sent++;
                end
            end
        end
        no_idle = 1'b0;

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
